FILE: hdl/bec_pkg.sv
`timescale 1ns / 1ps

package bec_pkg;

    localparam int ROW_W     = 12;
    localparam int COL_OUT_W = 10;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Up to three results caused by one input pixel. Result 0 is (row-1, col),
    // result 1 is (row, col-1), result 2 is (row, col) and closes the frame.
    typedef struct packed {
        logic [2:0]           px;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [1:0]           count;
    } bundle_t;

endpackage

FILE: hdl/binary_erosion_cross.sv
// Path: an accepted pixel is registered in the core's a_ stage, then its results in the emitter's b_reg.
// Throughput: one pixel per cycle while out_stall is low; results leave one per cycle, so the last
//   row's double results (triple at the final column) stall the input.
// The line memory has one write and one read port, touched once per pixel.
// Reset clears counters and handshake state; line memory is not cleared.
`timescale 1ns / 1ps

module binary_erosion_cross #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              fg_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              fg_out,
    output logic [bec_pkg::ROW_W-1:0]         out_row,
    output logic [bec_pkg::COL_OUT_W-1:0]     out_col,
    output logic                              last_of_run,
    output logic                              end_of_frame,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bec_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    import bec_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic             restart;
    logic             bnd_valid;
    logic             bnd_ready;
    bundle_t          bnd;

    bec_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .w_last  (w_last),
        .h_last  (h_last),
        .restart (restart)
    );

    bec_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fg_in     (fg_in),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .w_last    (w_last),
        .h_last    (h_last),
        .restart   (restart),
        .bnd_valid (bnd_valid),
        .bnd       (bnd),
        .bnd_ready (bnd_ready)
    );

    bec_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .bnd_valid    (bnd_valid),
        .bnd          (bnd),
        .bnd_ready    (bnd_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fg_out       (fg_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

endmodule

FILE: hdl/bec_ram.sv
`timescale 1ns / 1ps

module bec_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/bec_cfg.sv
`timescale 1ns / 1ps

module bec_cfg #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bec_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [$clog2(MAX_WIDTH)-1:0]      w_last,
    output logic [bec_pkg::ROW_W-1:0]         h_last,
    output logic                              restart
);

    import bec_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    localparam logic [10:0]      FW_RESET = 11'd640;
    localparam logic [ROW_W-1:0] FH_RESET = 12'd480;

    logic [10:0]      fw_reg;
    logic [ROW_W-1:0] fh_reg;
    logic [CW-1:0]    w_last_reg;
    logic [ROW_W-1:0] h_last_reg;
    logic             wr_en;
    reg_idx_t         idx;

    // Saturate to [3, MAX_WIDTH] and return the last column index.
    function automatic logic [CW-1:0] width_last(input logic [10:0] fw);
        logic [31:0] fw_ext;
        fw_ext = {21'd0, fw};
        if (fw < 11'd3)
            return CW'(2);
        else if (fw_ext > 32'(MAX_WIDTH))
            return CW'(MAX_WIDTH - 1);
        else
            return CW'(fw - 11'd1);
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [ROW_W-1:0] fh);
        if (fh < 12'd3)
            return 12'd2;
        else
            return fh - 12'd1;
    endfunction

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= FW_RESET;
            fh_reg      <= FH_RESET;
            w_last_reg  <= width_last(FW_RESET);
            h_last_reg  <= height_last(FH_RESET);
        end
        else
        begin
            if (wr_en)
            begin
                unique case (idx)
                    REG_FRAME_WIDTH:
                    begin
                        fw_reg     <= pwdata[10:0];
                        w_last_reg <= width_last(pwdata[10:0]);
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        fh_reg     <= pwdata[ROW_W-1:0];
                        h_last_reg <= height_last(pwdata[ROW_W-1:0]);
                    end
                    default:
                    begin
                        fw_reg <= fw_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = {21'd0, fw_reg};
            REG_FRAME_HEIGHT: prdata = {20'd0, fh_reg};
            default:          prdata = '0;
        endcase
    end

    assign w_last  = w_last_reg;
    assign h_last  = h_last_reg;
    // Restart the frame at the same edge that writes the register.
    assign restart = wr_en;

endmodule

FILE: hdl/bec_core.sv
`timescale 1ns / 1ps

module bec_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fg_in,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [$clog2(MAX_WIDTH)-1:0]  w_last,
    input  logic [bec_pkg::ROW_W-1:0]     h_last,
    input  logic                          restart,
    output logic                          bnd_valid,
    output bec_pkg::bundle_t              bnd,
    input  logic                          bnd_ready
);

    import bec_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Line memory entry: bit 1 holds row r-1, bit 0 holds row r-2.
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [1:0]       win_reg;

    logic             a_valid_reg;
    logic             a_x_reg;
    logic [CW-1:0]    a_col_reg;
    logic [ROW_W-1:0] a_row_reg;
    logic             a_ge2_reg;
    logic             a_c0_reg;
    logic             a_cge2_reg;
    logic             a_clast_reg;
    logic             a_p1_reg;
    logic             a_p2_reg;
    logic [1:0]       a_count_reg;

    logic [1:0]       hold_reg;
    logic             prev_reg;

    logic             accept;
    logic             a_adv;
    logic             c_last;
    logic             r_last;
    logic [1:0]       count_next;
    logic [CW-1:0]    raddr;
    logic [1:0]       rdata;

    assign c_last   = (col_reg == w_last);
    assign r_last   = (row_reg == h_last);
    assign a_adv    = a_valid_reg && ((a_count_reg == 2'd0) || bnd_ready);
    assign in_stall = a_valid_reg && !a_adv;
    assign accept   = in_valid && !in_stall;
    // At the last column fetch column 0, which this row has already rewritten.
    assign raddr    = c_last ? '0 : col_reg + CW'(1);

    always_comb
    begin
        if (row_reg == '0)
            count_next = 2'd0;
        else if (r_last && c_last)
            count_next = 2'd3;
        else if (r_last && (col_reg != '0))
            count_next = 2'd2;
        else
            count_next = 2'd1;
    end

    bec_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (a_adv),
        .waddr (a_col_reg),
        .wdata ({a_x_reg, hold_reg[1]}),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            win_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_count_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
                a_count_reg <= count_next;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end

            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                win_reg <= '0;
            end
            else if (accept)
            begin
                if (c_last)
                begin
                    col_reg <= '0;
                    win_reg <= '0;
                    row_reg <= r_last ? '0 : row_reg + 12'd1;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                    win_reg <= {win_reg[0], fg_in};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg     <= fg_in;
            a_col_reg   <= col_reg;
            a_row_reg   <= row_reg;
            a_ge2_reg   <= (row_reg[ROW_W-1:1] != '0);
            a_c0_reg    <= (col_reg == '0);
            a_cge2_reg  <= (col_reg[CW-1:1] != '0);
            a_clast_reg <= c_last;
            a_p1_reg    <= win_reg[0];
            a_p2_reg    <= win_reg[1];
        end
        if (a_adv)
        begin
            hold_reg <= rdata;
            prev_reg <= hold_reg[1];
        end
    end

    always_comb
    begin
        bnd.px[0] = hold_reg[1] & (hold_reg[0] | ~a_ge2_reg) & a_x_reg
                  & (prev_reg | a_c0_reg) & (rdata[1] | a_clast_reg);
        bnd.px[1] = a_p1_reg & a_x_reg & prev_reg & (a_p2_reg | ~a_cge2_reg);
        bnd.px[2] = a_x_reg & a_p1_reg & hold_reg[1];
        bnd.row   = a_row_reg;
        bnd.col   = COL_OUT_W'(a_col_reg);
        bnd.count = a_count_reg;
    end

    assign bnd_valid = a_valid_reg && (a_count_reg != 2'd0);

endmodule

FILE: hdl/bec_emit.sv
`timescale 1ns / 1ps

module bec_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          bnd_valid,
    input  bec_pkg::bundle_t              bnd,
    output logic                          bnd_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          fg_out,
    output logic [bec_pkg::ROW_W-1:0]     out_row,
    output logic [bec_pkg::COL_OUT_W-1:0] out_col,
    output logic                          last_of_run,
    output logic                          end_of_frame
);

    import bec_pkg::*;

    logic       b_valid_reg;
    bundle_t    b_reg;
    logic [1:0] idx_reg;
    logic       deliver;
    logic       is_last;

    assign deliver   = b_valid_reg && !out_stall;
    assign is_last   = (idx_reg == (b_reg.count - 2'd1));
    assign bnd_ready = !b_valid_reg || (deliver && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end
        else
        begin
            if (bnd_valid && bnd_ready)
            begin
                b_valid_reg <= 1'b1;
                idx_reg     <= 2'd0;
            end
            else if (deliver)
            begin
                if (is_last)
                    b_valid_reg <= 1'b0;
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bnd_valid && bnd_ready)
            b_reg <= bnd;
    end

    always_comb
    begin
        unique case (idx_reg)
            2'd0:
            begin
                fg_out  = b_reg.px[0];
                out_row = b_reg.row - 12'd1;
                out_col = b_reg.col;
            end
            2'd1:
            begin
                fg_out  = b_reg.px[1];
                out_row = b_reg.row;
                out_col = b_reg.col - 10'd1;
            end
            2'd2:
            begin
                fg_out  = b_reg.px[2];
                out_row = b_reg.row;
                out_col = b_reg.col;
            end
            default:
            begin
                fg_out  = 1'b0;
                out_row = b_reg.row;
                out_col = b_reg.col;
            end
        endcase
    end

    assign out_valid    = b_valid_reg;
    assign last_of_run  = is_last;
    assign end_of_frame = (idx_reg == 2'd2);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bec_pkg::*;

    localparam int LINE_MAX        = 1024;
    localparam int HEIGHT_MAX      = 4095;
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_ITEMS    = 40;
    localparam int MAX_REPORTS     = 40;

    typedef enum int {
        REG_FRAME_WIDTH  = 0,
        REG_FRAME_HEIGHT = 1
    } reg_index_e;

    typedef struct packed {
        logic                 fg;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
        logic                 eof;
    } eroded_px_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  fg_in;
    logic                  out_valid;
    logic                  out_stall;
    logic                  fg_out;
    logic [ROW_W-1:0]      out_row;
    logic [COL_OUT_W-1:0]  out_col;
    logic                  last_of_run;
    logic                  end_of_frame;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: registers as stored, two line buffers that swap roles per row.
    logic [10:0]  width_reg  = 11'd640;
    logic [11:0]  height_reg = 12'd480;
    bit           line_mem [2][LINE_MAX];
    bit           center_sel = 1'b0;
    int unsigned  col_cnt    = 0;
    int unsigned  row_cnt    = 0;
    logic [5:0]   recent_px  = '0;
    eroded_px_t   eroded_q[$];

    int mismatch_count = 0;
    int in_gap_max     = 0;
    int out_gap_max    = 0;
    int hold_req       = 0;

    binary_erosion_cross dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .fg_in        (fg_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fg_out       (fg_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned active_width();
        if (width_reg < 3)
            return 3;
        if (width_reg > LINE_MAX)
            return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg < 3)
            return 3;
        if (height_reg > HEIGHT_MAX)
            return HEIGHT_MAX;
        return height_reg;
    endfunction

    function automatic eroded_px_t pack_px(bit fg, int unsigned row, int unsigned col, bit eof);
        eroded_px_t p;
        p.fg   = fg;
        p.row  = row[ROW_W-1:0];
        p.col  = col[COL_OUT_W-1:0];
        p.last = 1'b0;
        p.eof  = eof;
        return p;
    endfunction

    // Queue the eroded pixels that one accepted input pixel releases.
    function automatic void erode_pixel(input bit x);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int          n;
        int          i;
        bit          px;
        bit          on_bottom_row;
        eroded_px_t  res [3];
        w = active_width();
        h = active_height();
        r = row_cnt;
        c = col_cnt;
        n = 0;
        if (c >= w)
            c = 0;
        if (r >= h)
            r = 0;
        on_bottom_row = (r == h - 1);
        if (r >= 1)
        begin
            px = line_mem[center_sel][c] & x;
            if (r >= 2)
                px &= line_mem[!center_sel][c];
            if (c >= 1)
                px &= line_mem[center_sel][c-1];
            if (c + 1 < w)
                px &= line_mem[center_sel][c+1];
            res[n] = pack_px(px, r - 1, c, 1'b0);
            n++;
        end
        // last row: its own pixels come out as they arrive, one column behind
        if (on_bottom_row && c >= 1)
        begin
            px = recent_px[0] & x & line_mem[center_sel][c-1];
            if (c >= 2)
                px &= recent_px[1];
            res[n] = pack_px(px, r, c - 1, 1'b0);
            n++;
        end
        if (on_bottom_row && c == w - 1)
        begin
            px = x & recent_px[0] & line_mem[center_sel][c];
            res[n] = pack_px(px, r, c, 1'b1);
            n++;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            eroded_q.push_back(res[i]);

        line_mem[!center_sel][c] = x;
        recent_px = {recent_px[4:0], x};
        c++;
        if (c >= w)
        begin
            center_sel = !center_sel;
            c = 0;
            recent_px = '0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endfunction

    function automatic int draw_wait(int max_wait);
        if (max_wait == 0 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, max_wait);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want, input eroded_px_t at);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("error: %s got %0h expected %0h (row %0d col %0d) at %0t",
                     field, got, want, at.row, at.col, $realtime);
    endtask

    task automatic send_pixel(input bit px);
        int gap;
        gap = draw_wait(in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        fg_in    <= px;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        erode_pixel(px);
    endtask

    task automatic send_pixels(input int count, input int density_pct);
        repeat (count) send_pixel($urandom_range(0, 99) < density_pct);
    endtask

    // Hold the input until every expected result is back, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (eroded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_e idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            width_reg = value[10:0];
        else
            height_reg = value[11:0];
        col_cnt   = 0;
        row_cnt   = 0;
        recent_px = '0;
    endtask

    task automatic set_frame(input int w, input int h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Default 640 x 480 geometry: a partial row 0 releases nothing.
    task automatic test_reset_defaults();
        in_gap_max  = 4;
        out_gap_max = 4;
        send_pixels(16, 90);
        drain();
    endtask

    task automatic test_directed();
        int i;
        in_gap_max  = 0;
        out_gap_max = 0;
        set_frame(3, 3);
        send_pixels(9, 100);
        // single hole in the middle, sent as the next frame without a restart
        for (i = 0; i < 9; i++)
            send_pixel(i != 4);
        drain();
        // below-minimum registers saturate to 3 x 3
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 0);
        for (i = 0; i < 9; i++)
            send_pixel(i[0]);
        drain();
    endtask

    task automatic test_wide_frames();
        in_gap_max  = 2;
        out_gap_max = 2;
        // oversize width saturates to the line buffer depth; a partial row 0 is silent
        set_frame(11'h7FF, 3);
        send_pixels(12, 90);
        drain();
        set_frame(3, HEIGHT_MAX);
        send_pixels(15, 80);
        drain();
        write_reg(REG_FRAME_HEIGHT, 2);
        send_pixels(9, 70);
        drain();
    endtask

    task automatic test_hold_off();
        in_gap_max  = 0;
        out_gap_max = 0;
        set_frame(6, 4);
        hold_req = HOLD_OFF_CYCLES;
        send_pixels(24, 85);
        drain();
        // pause mid-frame with nothing outstanding, then resume
        in_gap_max  = 16;
        out_gap_max = 16;
        send_pixels(10, 85);
        drain();
        send_pixels(14, 85);
        drain();
    endtask

    task automatic test_random_frames();
        int total;
        int w;
        int h;
        int count;
        int density;
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 4);
            if ($urandom_range(0, 1))
                set_frame(w, h);
            else
            begin
                write_reg(REG_FRAME_HEIGHT, h);
                write_reg(REG_FRAME_WIDTH, w);
            end
            in_gap_max  = $urandom_range(0, 1) ? 16 : 0;
            out_gap_max = $urandom_range(0, 1) ? 16 : 0;
            case ($urandom_range(0, 2))
                0: density = 50;
                1: density = 80;
                default: density = 95;
            endcase
            count = active_width() * active_height();
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, count - 1);
            send_pixels(count, density);
            total += count;
            drain();
        end
    endtask

    initial
    begin : result_sink
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
            end
            else
                n = draw_wait(out_gap_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1 && hold_req == 0)
                @(posedge clk);
        end
    end

    initial
    begin : result_check
        eroded_px_t want;
        eroded_px_t seen;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                seen = {fg_out, out_row, out_col, last_of_run, end_of_frame};
                if (eroded_q.size() == 0)
                    report_mismatch("result with nothing outstanding", 0, 0, seen);
                else
                begin
                    want = eroded_q.pop_front();
                    if (fg_out !== want.fg)
                        report_mismatch("fg_out", 32'(fg_out), 32'(want.fg), want);
                    if (out_row !== want.row)
                        report_mismatch("out_row", 32'(out_row), 32'(want.row), want);
                    if (out_col !== want.col)
                        report_mismatch("out_col", 32'(out_col), 32'(want.col), want);
                    if (last_of_run !== want.last)
                        report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last),
                                        want);
                    if (end_of_frame !== want.eof)
                        report_mismatch("end_of_frame", 32'(end_of_frame), 32'(want.eof),
                                        want);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction in %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        fg_in    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_wide_frames();
        test_hold_off();
        test_random_frames();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
